### rtl/core/gia_pkg.sv
// gia_pkg: types, constants and a helper function for the gamepad input block
// no dependencies; every other file of the block but gia_if refers to it by scoped names
package gia_pkg;

    // configuration register indexes
    localparam logic REG_REPEAT_DELAY  = 1'b0;
    localparam logic REG_DIR_THRESHOLD = 1'b1;

    // configuration reset values
    localparam logic [7:0] REPEAT_DELAY_RST  = 8'd20;
    localparam logic [6:0] DIR_THRESHOLD_RST = 7'd32;

    // controller type codes
    localparam logic [2:0] CTRL_NONE    = 3'd0;
    localparam logic [2:0] CTRL_CLASSIC = 3'd1;
    localparam logic [2:0] CTRL_LEFT    = 3'd2;
    localparam logic [2:0] CTRL_RIGHT   = 3'd3;
    localparam logic [2:0] CTRL_FULL    = 3'd4;

    // raw button bit positions
    localparam int RAW_ZL    = 6;
    localparam int RAW_ZR    = 7;
    localparam int RAW_PLUS  = 8;
    localparam int RAW_MINUS = 9;
    localparam int RAW_UP    = 10;
    localparam int RAW_DOWN  = 11;
    localparam int RAW_LEFT  = 12;
    localparam int RAW_RIGHT = 13;

    // held button bit positions
    localparam int HELD_L     = 4;
    localparam int HELD_R     = 5;
    localparam int HELD_Z     = 6;
    localparam int HELD_START = 7;

    // direction bit positions
    localparam int DIR_LEFT  = 0;
    localparam int DIR_RIGHT = 1;
    localparam int DIR_DOWN  = 2;
    localparam int DIR_UP    = 3;

    // one input word
    typedef struct packed {
        logic [1:0]         pad_index;
        logic               connected;
        logic [2:0]         style_bits;
        logic [13:0]        raw_buttons;
        logic signed [15:0] left_x;
        logic signed [15:0] left_y;
        logic signed [15:0] right_x;
        logic signed [15:0] right_y;
    } sample_t;

    // per-pad state entry
    typedef struct packed {
        logic [7:0] prev_held;
        logic [7:0] button_repeat_count;
        logic [7:0] dir_repeat_count;
        logic [3:0] last_dir;
    } pad_state_t;

    // one result word
    typedef struct packed {
        logic [1:0]        pad_out;
        logic [2:0]        ctrl_type;
        logic [7:0]        held;
        logic [7:0]        pressed;
        logic [7:0]        held_repeat;
        logic [3:0]        dir_bits;
        logic [3:0]        dir_repeat;
        logic signed [7:0] main_x;
        logic signed [7:0] main_y;
        logic signed [7:0] sub_x;
        logic signed [7:0] sub_y;
        logic [1:0]        trigger_full;
    } result_t;

    // stick / 256 truncated toward zero; the quotient always fits in -128..127
    function automatic logic signed [7:0] scale_stick(input logic signed [15:0] raw);
        logic signed [7:0] q;
        begin
            q = raw[15:8];
            if (raw[15] && (raw[7:0] != 8'd0))
            begin
                q = q + 8'sd1;
            end
            return q;
        end
    endfunction

endpackage

### rtl/core/gia_if.sv
// gia_if: valid/ready channel interfaces for samples, results and register writes
// no dependency on gia_pkg; the field widths only mirror those of its types
interface gia_sample_if;
    logic               valid;
    logic               ready;
    logic [1:0]         pad_index;
    logic               connected;
    logic [2:0]         style_bits;
    logic [13:0]        raw_buttons;
    logic signed [15:0] left_x;
    logic signed [15:0] left_y;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;

    modport source (
        output valid, pad_index, connected, style_bits, raw_buttons,
               left_x, left_y, right_x, right_y,
        input  ready
    );
    modport sink (
        input  valid, pad_index, connected, style_bits, raw_buttons,
               left_x, left_y, right_x, right_y,
        output ready
    );
endinterface

interface gia_result_if;
    logic              valid;
    logic              ready;
    logic [1:0]        pad_out;
    logic [2:0]        ctrl_type;
    logic [7:0]        held;
    logic [7:0]        pressed;
    logic [7:0]        held_repeat;
    logic [3:0]        dir_bits;
    logic [3:0]        dir_repeat;
    logic signed [7:0] main_x;
    logic signed [7:0] main_y;
    logic signed [7:0] sub_x;
    logic signed [7:0] sub_y;
    logic [1:0]        trigger_full;

    modport source (
        output valid, pad_out, ctrl_type, held, pressed, held_repeat, dir_bits,
               dir_repeat, main_x, main_y, sub_x, sub_y, trigger_full,
        input  ready
    );
    modport sink (
        input  valid, pad_out, ctrl_type, held, pressed, held_repeat, dir_bits,
               dir_repeat, main_x, main_y, sub_x, sub_y, trigger_full,
        output ready
    );
endinterface

interface gia_cfg_if;
    logic       valid;
    logic       ready;
    logic       index;
    logic [7:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

### rtl/core/gia_state_mem.sv
// gia_state_mem: per-pad state memory, registered read, valid bit per entry
// depends on gia_pkg (pad_state_t); unwritten entries read as zero
module gia_state_mem #(
    parameter int DEPTH = 4,
    parameter int AW    = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr,
    output gia_pkg::pad_state_t rd_data,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  gia_pkg::pad_state_t wr_data
);

    gia_pkg::pad_state_t mem [DEPTH];
    logic [DEPTH-1:0]    vld_reg;
    gia_pkg::pad_state_t rd_data_reg;

    // entry storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // entry valid bits, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (wr_en)
        begin
            vld_reg[wr_addr] <= 1'b1;
        end
    end

    // registered read with write-through forwarding for the same entry
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else if (vld_reg[rd_addr])
            begin
                rd_data_reg <= mem[rd_addr];
            end
            else
            begin
                rd_data_reg <= '0;
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/gia_cond.sv
// gia_cond: conditions one sample against its pad state, builds result and new state
// depends on gia_pkg (types, codes, scale_stick)
module gia_cond (
    input  gia_pkg::sample_t    sample,
    input  logic                in_range,
    input  gia_pkg::pad_state_t state,
    input  logic [7:0]          repeat_delay,
    input  logic [6:0]          dir_threshold,
    output gia_pkg::result_t    result,
    output gia_pkg::pad_state_t state_next,
    output logic                state_wr
);

    logic [7:0]        held;
    logic [3:0]        dir;
    logic [2:0]        ctype;
    logic signed [7:0] mx;
    logic signed [7:0] my;
    logic signed [8:0] thr_pos;
    logic signed [8:0] thr_neg;
    logic [7:0]        held_rpt;
    logic [7:0]        btn_cnt;
    logic [3:0]        dir_rpt;
    logic [7:0]        dir_cnt;
    logic [13:0]       raw;

    // controller type, classic first, then left half, then right half
    always_comb
    begin
        if (sample.style_bits[0])
        begin
            ctype = gia_pkg::CTRL_CLASSIC;
        end
        else if (sample.style_bits[1])
        begin
            ctype = gia_pkg::CTRL_LEFT;
        end
        else if (sample.style_bits[2])
        begin
            ctype = gia_pkg::CTRL_RIGHT;
        end
        else
        begin
            ctype = gia_pkg::CTRL_FULL;
        end
    end

    // button map and sticks
    assign raw = sample.raw_buttons;
    assign mx  = gia_pkg::scale_stick(sample.left_x);
    assign my  = gia_pkg::scale_stick(sample.left_y);

    always_comb
    begin
        held = {2'b00, raw[5:0]};
        held[gia_pkg::HELD_L]     = raw[4] | raw[gia_pkg::RAW_ZL];
        held[gia_pkg::HELD_Z]     = raw[gia_pkg::RAW_ZR];
        held[gia_pkg::HELD_START] = raw[gia_pkg::RAW_PLUS] | raw[gia_pkg::RAW_MINUS];
    end

    // direction bits: d-pad or main stick strictly beyond threshold
    assign thr_pos = $signed({2'b00, dir_threshold});
    assign thr_neg = -thr_pos;

    always_comb
    begin
        dir = 4'd0;
        dir[gia_pkg::DIR_LEFT]  = raw[gia_pkg::RAW_LEFT]  | ($signed({mx[7], mx}) < thr_neg);
        dir[gia_pkg::DIR_RIGHT] = raw[gia_pkg::RAW_RIGHT] | ($signed({mx[7], mx}) > thr_pos);
        dir[gia_pkg::DIR_DOWN]  = raw[gia_pkg::RAW_DOWN]  | ($signed({my[7], my}) < thr_neg);
        dir[gia_pkg::DIR_UP]    = raw[gia_pkg::RAW_UP]    | ($signed({my[7], my}) > thr_pos);
    end

    // button auto-repeat
    always_comb
    begin
        if ((held != 8'd0) && (held == state.prev_held))
        begin
            if (state.button_repeat_count >= repeat_delay)
            begin
                held_rpt = held;
                btn_cnt  = state.button_repeat_count;
            end
            else
            begin
                held_rpt = 8'd0;
                btn_cnt  = state.button_repeat_count + 8'd1;
            end
        end
        else
        begin
            held_rpt = held;
            btn_cnt  = 8'd0;
        end
    end

    // direction auto-repeat
    always_comb
    begin
        if ((dir != 4'd0) && (dir == state.last_dir))
        begin
            if (state.dir_repeat_count >= repeat_delay)
            begin
                dir_rpt = dir;
                dir_cnt = state.dir_repeat_count;
            end
            else
            begin
                dir_rpt = 4'd0;
                dir_cnt = state.dir_repeat_count + 8'd1;
            end
        end
        else
        begin
            dir_rpt = dir;
            dir_cnt = 8'd0;
        end
    end

    // result word and state write-back; out-of-range or disconnected pads clear all fields but pad_out
    always_comb
    begin
        result         = '0;
        result.pad_out = sample.pad_index;
        state_next     = '0;
        state_wr       = in_range;
        if (in_range && sample.connected)
        begin
            result.ctrl_type    = ctype;
            result.held         = held;
            result.pressed      = held & ~state.prev_held;
            result.held_repeat  = held_rpt;
            result.dir_bits     = dir;
            result.dir_repeat   = dir_rpt;
            result.main_x       = mx;
            result.main_y       = my;
            result.sub_x        = gia_pkg::scale_stick(sample.right_x);
            result.sub_y        = gia_pkg::scale_stick(sample.right_y);
            result.trigger_full = {held[gia_pkg::HELD_R], held[gia_pkg::HELD_L]};
            state_next.prev_held           = held;
            state_next.button_repeat_count = btn_cnt;
            state_next.dir_repeat_count    = dir_cnt;
            state_next.last_dir            = dir;
        end
    end

endmodule

### rtl/core/gamepad_input_auto_repeat.sv
// Gamepad input conditioner with button and direction auto-repeat. Each accepted
// sample word yields exactly one result word, in order. The sample enters the compute
// stage while the pad's state entry is read from a synchronous memory at the accepting
// edge; as the stage advances, the result it computes lands in the output register
// and the entry is written back. One sample per cycle is sustained while the output
// is taken; back-to-back samples for the same pad are forwarded from the write-back
// path, so no bubble is needed. State is valid right after reset.
// Configuration writes are always ready and take effect on the next sample.
// depends on gia_pkg, gia_if, gia_state_mem, gia_cond
module gamepad_input_auto_repeat #(
    parameter int NUM_PADS = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    gia_sample_if.sink   in,
    gia_result_if.source out,
    gia_cfg_if.sink      cfg
);

    localparam int AW = (NUM_PADS > 1) ? $clog2(NUM_PADS) : 1;

    logic [7:0]          repeat_delay_reg;
    logic [6:0]          dir_threshold_reg;
    gia_pkg::sample_t    in_word;
    logic                in_range;
    logic                in_acc;
    logic                s1_vld_reg;
    gia_pkg::sample_t    s1_reg;
    logic                s1_range_reg;
    logic                s1_adv;
    logic                out_vld_reg;
    gia_pkg::result_t    out_reg;
    gia_pkg::result_t    res;
    gia_pkg::pad_state_t rd_state;
    gia_pkg::pad_state_t wr_state;
    logic                wr_req;
    logic                wr_en;

    // configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repeat_delay_reg  <= gia_pkg::REPEAT_DELAY_RST;
            dir_threshold_reg <= gia_pkg::DIR_THRESHOLD_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                gia_pkg::REG_REPEAT_DELAY:  repeat_delay_reg  <= cfg.data;
                gia_pkg::REG_DIR_THRESHOLD: dir_threshold_reg <= cfg.data[6:0];
                default:                    repeat_delay_reg  <= repeat_delay_reg;
            endcase
        end
    end

    // input word gathering and handshake
    always_comb
    begin
        in_word.pad_index   = in.pad_index;
        in_word.connected   = in.connected;
        in_word.style_bits  = in.style_bits;
        in_word.raw_buttons = in.raw_buttons;
        in_word.left_x      = in.left_x;
        in_word.left_y      = in.left_y;
        in_word.right_x     = in.right_x;
        in_word.right_y     = in.right_y;
    end

    assign in_range = ({3'b000, in.pad_index} < 5'(NUM_PADS));
    assign s1_adv   = s1_vld_reg && (!out_vld_reg || out.ready);
    assign in.ready = !s1_vld_reg || s1_adv;
    assign in_acc   = in.valid && in.ready;

    // compute stage holding the sample while its state entry is read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else if (in.ready)
        begin
            s1_vld_reg <= in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_reg       <= in_word;
            s1_range_reg <= in_range;
        end
    end

    // per-pad state memory
    gia_state_mem #(
        .DEPTH (NUM_PADS),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_acc && in_range),
        .rd_addr (AW'(in.pad_index)),
        .rd_data (rd_state),
        .wr_en   (wr_en),
        .wr_addr (AW'(s1_reg.pad_index)),
        .wr_data (wr_state)
    );

    // result and next state
    gia_cond u_cond (
        .sample        (s1_reg),
        .in_range      (s1_range_reg),
        .state         (rd_state),
        .repeat_delay  (repeat_delay_reg),
        .dir_threshold (dir_threshold_reg),
        .result        (res),
        .state_next    (wr_state),
        .state_wr      (wr_req)
    );

    assign wr_en = s1_adv && wr_req;

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (!out_vld_reg || out.ready)
        begin
            out_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_reg <= res;
        end
    end

    assign out.valid        = out_vld_reg;
    assign out.pad_out      = out_reg.pad_out;
    assign out.ctrl_type    = out_reg.ctrl_type;
    assign out.held         = out_reg.held;
    assign out.pressed      = out_reg.pressed;
    assign out.held_repeat  = out_reg.held_repeat;
    assign out.dir_bits     = out_reg.dir_bits;
    assign out.dir_repeat   = out_reg.dir_repeat;
    assign out.main_x       = out_reg.main_x;
    assign out.main_y       = out_reg.main_y;
    assign out.sub_x        = out_reg.sub_x;
    assign out.sub_y        = out_reg.sub_y;
    assign out.trigger_full = out_reg.trigger_full;

    // a stalled compute stage keeps its word
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_vld_reg && !s1_adv |=> s1_vld_reg)
        else $error("compute stage lost a stalled word");

    // state is written back only as a word leaves the compute stage
    a_wr_adv: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> s1_vld_reg && (!out_vld_reg || out.ready))
        else $error("state write without stage advance");

    // a taken result with nothing behind it empties the output register
    a_out_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && out.ready && !s1_vld_reg |=> !out_vld_reg)
        else $error("result repeated after it was taken");

    // newly pressed buttons are a subset of held buttons
    a_pressed: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> ((out_reg.pressed & ~out_reg.held) == 8'd0))
        else $error("pressed bit without held bit");

    // repeat output shows the held set or nothing
    a_repeat: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> (out_reg.held_repeat == 8'd0) || (out_reg.held_repeat == out_reg.held))
        else $error("button repeat differs from held set");

endmodule
